// ===== design/asau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active stress activation update: shared package
// Widths, register indexes, region mode codes and the types that pass
// between the front, the queue and the back of the update core.
// ----------------------------------------------------------------------------
package asau_pkg;

    // Saturation width of the updated activation.
    localparam int VALUE_WIDTH = 32;

    // Fixed field widths.
    localparam int FIELD_W  = 32;
    localparam int GAIN_W   = 32;
    localparam int WORD_W   = 64;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 3;

    // Gains are Q8.24.
    localparam int GAIN_FRAC = 24;

    // Decoupling queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_X_WORD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y_WORD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_BOUNDS        = 3'd6;

    // Region modes; the fourth code selects no region.
    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOX     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ELLIPSE = 2'd2;

    // Weakness factor of 1.0 in Q8.24.
    localparam logic [GAIN_W-1:0] WEAKNESS_RESET = 32'h0100_0000;

    // Region settings used by the front.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] x_word;
        logic [WORD_W-1:0] y_word;
        logic [WORD_W-1:0] z_bounds;
    } t_region_cfg;

    // Gain settings used by the back.
    typedef struct packed {
        logic [GAIN_W-1:0] drive_gain;
        logic [GAIN_W-1:0] decay_gain;
        logic [GAIN_W-1:0] region_scale;
    } t_gain_cfg;

    // One classified node request, as it waits in the queue.
    typedef struct packed {
        logic signed [FIELD_W-1:0] potential;
        logic signed [FIELD_W-1:0] activation;
        logic                      in_region;
    } t_item;

endpackage

// ===== design/asau_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active stress activation update: region classifier
// Four-stage pipeline that accepts node requests and decides whether the
// node lies in the configured box or ellipse region.
// ----------------------------------------------------------------------------
module asau_front
    import asau_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [FIELD_W-1:0] i_potential,
    input  logic signed [FIELD_W-1:0] i_activation,
    input  logic signed [FIELD_W-1:0] i_coord_x,
    input  logic signed [FIELD_W-1:0] i_coord_y,
    input  logic signed [FIELD_W-1:0] i_coord_z,
    input  t_region_cfg               i_region_cfg,
    output logic                      o_push,
    output t_item                     o_item,
    input  logic                      i_queue_ready
);

    // Fields that ride along the pipeline unchanged.
    typedef struct packed {
        logic signed [FIELD_W-1:0] potential;
        logic signed [FIELD_W-1:0] activation;
        logic [MODE_W-1:0]         mode;
        logic                      box_hit;
        logic                      z_hit;
    } t_front_tag;

    localparam int PROD_W = 2 * FIELD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CMP_W  = SUM_W + 1;
    localparam int ONE_EXP = 48;
    localparam logic [CMP_W-1:0] ELL_ONE = CMP_W'(1) << ONE_EXP;
    // High partial sums at or above this bit already exceed the unit level.
    localparam int HI_LIMIT = ONE_EXP + 1 - FIELD_W;

    // Magnitude of the difference of two signed values; it always fits 32 bits.
    function automatic logic [FIELD_W-1:0] diff_mag(logic [FIELD_W-1:0] a,
                                                   logic [FIELD_W-1:0] b);
        logic [FIELD_W:0] d;
        logic [FIELD_W:0] nd;
        d  = {a[FIELD_W-1], a} - {b[FIELD_W-1], b};
        nd = (~d) + 1'b1;
        return d[FIELD_W] ? nd[FIELD_W-1:0] : d[FIELD_W-1:0];
    endfunction

    // Open interval test against a word with min low and max high.
    function automatic logic open_range(logic [WORD_W-1:0] w, logic signed [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] lo;
        logic signed [FIELD_W-1:0] hi;
        lo = $signed(w[FIELD_W-1:0]);
        hi = $signed(w[WORD_W-1:FIELD_W]);
        return (lo < v) && (v < hi);
    endfunction

    logic en;

    logic               r_valid1, r_valid2, r_valid3, r_valid4;
    t_front_tag         r_tag1, r_tag2, r_tag3, r_tag4;
    t_front_tag         n_tag1;
    logic [FIELD_W-1:0] r_mx, r_my, n_mx, n_my;
    logic [PROD_W-1:0]  r_sqx, r_sqy;
    logic [PROD_W-1:0]  r_phx, r_plx, r_phy, r_ply;
    logic [SUM_W-1:0]   r_ph, r_pl;
    logic [CMP_W-1:0]   ell_sum;
    logic               ell_hit;
    logic               hit;

    // The whole pipeline advances together when its last stage can drain.
    assign en      = !r_valid4 || i_queue_ready;
    assign o_ready = en;
    assign o_push  = r_valid4 && i_queue_ready;

    // First stage: interval tests and distances to the ellipse center.
    always_comb begin
        n_tag1.potential  = i_potential;
        n_tag1.activation = i_activation;
        n_tag1.mode       = i_region_cfg.mode;
        n_tag1.box_hit    = open_range(i_region_cfg.x_word, i_coord_x) &&
                            open_range(i_region_cfg.y_word, i_coord_y);
        n_tag1.z_hit      = open_range(i_region_cfg.z_bounds, i_coord_z);
        n_mx = diff_mag(i_coord_x, i_region_cfg.x_word[FIELD_W-1:0]);
        n_my = diff_mag(i_coord_y, i_region_cfg.y_word[FIELD_W-1:0]);
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
            r_valid4 <= 1'b0;
        end else if (en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
            r_valid4 <= r_valid3;
        end
    end

    // Datapath: squares, partial products with the inverse axes, then sums.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag1 <= n_tag1;
            r_mx   <= n_mx;
            r_my   <= n_my;

            r_tag2 <= r_tag1;
            r_sqx  <= r_mx * r_mx;
            r_sqy  <= r_my * r_my;

            r_tag3 <= r_tag2;
            r_phx  <= r_sqx[PROD_W-1:FIELD_W] * i_region_cfg.x_word[WORD_W-1:FIELD_W];
            r_plx  <= r_sqx[FIELD_W-1:0]      * i_region_cfg.x_word[WORD_W-1:FIELD_W];
            r_phy  <= r_sqy[PROD_W-1:FIELD_W] * i_region_cfg.y_word[WORD_W-1:FIELD_W];
            r_ply  <= r_sqy[FIELD_W-1:0]      * i_region_cfg.y_word[WORD_W-1:FIELD_W];

            r_tag4 <= r_tag3;
            r_ph   <= SUM_W'(r_phx) + SUM_W'(r_phy);
            r_pl   <= SUM_W'(r_plx) + SUM_W'(r_ply);
        end
    end

    // Last stage: ellipse level against 1.0 and the final region decision.
    always_comb begin
        ell_sum = CMP_W'({r_ph[HI_LIMIT-1:0], {FIELD_W{1'b0}}}) + CMP_W'(r_pl);
        ell_hit = (r_ph[SUM_W-1:HI_LIMIT] == '0) && (ell_sum <= ELL_ONE);
        case (r_tag4.mode)
            MODE_BOX:     hit = r_tag4.box_hit && r_tag4.z_hit;
            MODE_ELLIPSE: hit = ell_hit && r_tag4.z_hit;
            default:      hit = 1'b0;
        endcase
        o_item.potential  = r_tag4.potential;
        o_item.activation = r_tag4.activation;
        o_item.in_region  = hit;
    end

endmodule

// ===== design/asau_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active stress activation update: decoupling queue
// Small register queue between the classifier and the update pipeline.
// ----------------------------------------------------------------------------
module asau_queue
    import asau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_not_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_not_empty
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_not_full  = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // The classifier must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == QCNT_W'(QUEUE_DEPTH))))
        else $error("queue push while full");

    // The update pipeline must never pop an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && (r_count == '0)))
        else $error("queue pop while empty");

    // The fill count grows by one on a push without a pop.
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == QCNT_W'($past(r_count) + 1'b1)))
        else $error("queue count lost a push");

endmodule

// ===== design/asau_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active stress activation update: update pipeline
// Five-stage pipeline that forms the Euler increment, applies the region
// weakness, adds it to the activation and saturates the result.
// ----------------------------------------------------------------------------
module asau_back
    import asau_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_gain_cfg                 i_gain_cfg,
    input  logic                      i_queue_valid,
    input  t_item                     i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [FIELD_W-1:0] o_new_activation,
    output logic                      o_in_region,
    output logic                      o_saturated
);

    localparam int PROD_W = 2 * FIELD_W;
    localparam int MAG_W  = PROD_W - GAIN_FRAC;
    localparam int HI_W   = MAG_W - FIELD_W;
    localparam int WH_W   = HI_W + GAIN_W;
    localparam int WMAG_W = MAG_W + HI_W + 1;
    localparam int SUM_W  = WMAG_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic en;

    logic                      r_valid1, r_valid2, r_valid3, r_valid4, r_valid5;
    logic signed [FIELD_W-1:0] r_act1, r_act2, r_act3, r_act4;
    logic                      r_reg1, r_reg2, r_reg3, r_reg4;
    logic                      r_neg2, r_neg3, r_neg4;
    logic [PROD_W-1:0]         r_d, r_e, n_d, n_e;
    logic [FIELD_W-1:0]        abs_act;
    logic [FIELD_W-1:0]        neg_act;
    logic [PROD_W-1:0]         raw;
    logic [MAG_W-1:0]          r_mag2, r_mag3;
    logic                      n_neg2;
    logic [WH_W-1:0]           r_wh;
    logic [PROD_W-1:0]         r_wl;
    logic [WMAG_W-1:0]         r_mag4, n_mag4;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   n_out;
    logic                      n_sat;

    logic signed [FIELD_W-1:0] r_new_activation;
    logic                      r_in_region;
    logic                      r_saturated;

    // The pipeline advances whenever the output register can be refilled.
    assign en    = !r_valid5 || i_ready;
    assign o_pop = en && i_queue_valid;

    // Stage one: drive and decay products.
    always_comb begin
        neg_act = (~i_item.activation) + 1'b1;
        abs_act = i_item.activation[FIELD_W-1] ? neg_act : i_item.activation;
        n_d = '0;
        if (i_item.potential > 0) begin
            n_d = i_gain_cfg.drive_gain * {1'b0, i_item.potential[FIELD_W-2:0]};
        end
        n_e = i_gain_cfg.decay_gain * abs_act;
    end

    // Stage two: signed difference as sign and magnitude, with the 24 gain fraction bits cut off.
    always_comb begin
        n_neg2 = 1'b0;
        if (r_act1[FIELD_W-1]) begin
            raw = r_d + r_e;
        end else if (r_d >= r_e) begin
            raw = r_d - r_e;
        end else begin
            raw    = r_e - r_d;
            n_neg2 = 1'b1;
        end
    end

    // Stage four: weakened magnitude inside the region.
    always_comb begin
        if (r_reg3) begin
            n_mag4 = WMAG_W'({r_wh, 8'b0}) + WMAG_W'(r_wl[PROD_W-1:GAIN_FRAC]);
        end else begin
            n_mag4 = WMAG_W'(r_mag3);
        end
    end

    // Stage five: add to the activation and saturate.
    always_comb begin
        if (r_neg4) begin
            sum = SUM_W'(r_act4) - $signed({2'b00, r_mag4});
        end else begin
            sum = SUM_W'(r_act4) + $signed({2'b00, r_mag4});
        end
        n_sat = 1'b0;
        n_out = sum;
        if (sum > SAT_HI) begin
            n_out = SAT_HI;
            n_sat = 1'b1;
        end else if (sum < SAT_LO) begin
            n_out = SAT_LO;
            n_sat = 1'b1;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
            r_valid4 <= 1'b0;
            r_valid5 <= 1'b0;
        end else if (en) begin
            r_valid1 <= i_queue_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
            r_valid4 <= r_valid3;
            r_valid5 <= r_valid4;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_act1 <= i_item.activation;
            r_reg1 <= i_item.in_region;
            r_d    <= n_d;
            r_e    <= n_e;

            r_act2 <= r_act1;
            r_reg2 <= r_reg1;
            r_neg2 <= n_neg2;
            r_mag2 <= raw[PROD_W-1:GAIN_FRAC];

            r_act3 <= r_act2;
            r_reg3 <= r_reg2;
            r_neg3 <= r_neg2;
            r_mag3 <= r_mag2;
            r_wh   <= r_mag2[MAG_W-1:FIELD_W] * i_gain_cfg.region_scale;
            r_wl   <= r_mag2[FIELD_W-1:0]     * i_gain_cfg.region_scale;

            r_act4 <= r_act3;
            r_reg4 <= r_reg3;
            r_neg4 <= r_neg3;
            r_mag4 <= n_mag4;

            r_new_activation <= n_out[FIELD_W-1:0];
            r_in_region      <= r_reg4;
            r_saturated      <= n_sat;
        end
    end

    assign o_valid          = r_valid5;
    assign o_new_activation = r_new_activation;
    assign o_in_region      = r_in_region;
    assign o_saturated      = r_saturated;

endmodule

// ===== design/active_stress_activation_update_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active stress activation update core
// Explicit Euler step of the fiber activation of one mesh node per request,
// with a weakness factor applied inside a box or ellipse region.
// ----------------------------------------------------------------------------
// Usage:
//   Node requests (potential, activation, x, y, z) enter on the i_valid /
//   o_ready channel; results (new activation, region flag, saturation flag)
//   leave on o_valid / i_ready. Both follow a valid/ready handshake.
//   Registers are written on the i_cfg_valid / o_cfg_ready channel, which is
//   always ready; indexes beyond the register list are ignored. Write them
//   only while no request is in flight.
//   A request passes through the four-stage region classifier, the queue
//   and the five-stage update pipeline in that order. Throughput: one
//   request per cycle while the receiver does not stall; each pipeline
//   advances one stage per cycle when it is not held.
//   A four-entry queue sits between the two pipelines. When the receiver
//   stalls, the update pipeline holds, the queue fills, and then o_ready
//   drops; no request or result is lost.
//   Reset (synchronous, active low) empties both pipelines and the queue
//   and loads the register defaults: zero gains, weakness 1.0, no region.
// ----------------------------------------------------------------------------
module active_stress_activation_update_core
    import asau_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [FIELD_W-1:0]   i_potential,
    input  logic signed [FIELD_W-1:0]   i_activation,
    input  logic signed [FIELD_W-1:0]   i_coord_x,
    input  logic signed [FIELD_W-1:0]   i_coord_y,
    input  logic signed [FIELD_W-1:0]   i_coord_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [FIELD_W-1:0]   o_new_activation,
    output logic                        o_in_region,
    output logic                        o_saturated,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [WORD_W-1:0]           i_cfg_data
);

    t_region_cfg r_region_cfg;
    t_gain_cfg   r_gain_cfg;

    logic  push;
    logic  pop;
    logic  queue_not_full;
    logic  queue_not_empty;
    t_item front_item;
    t_item queue_item;

    // Register writes are taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_cfg.drive_gain      <= '0;
            r_gain_cfg.decay_gain      <= '0;
            r_gain_cfg.region_scale    <= WEAKNESS_RESET;
            r_region_cfg.mode          <= MODE_NONE;
            r_region_cfg.x_word        <= '0;
            r_region_cfg.y_word        <= '0;
            r_region_cfg.z_bounds      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DRIVE_GAIN:      r_gain_cfg.drive_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_DECAY_GAIN:      r_gain_cfg.decay_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_REGION_SCALE:    r_gain_cfg.region_scale    <= i_cfg_data[GAIN_W-1:0];
                CFG_REGION_MODE:     r_region_cfg.mode          <= i_cfg_data[MODE_W-1:0];
                CFG_REGION_X_WORD:   r_region_cfg.x_word        <= i_cfg_data;
                CFG_REGION_Y_WORD:   r_region_cfg.y_word        <= i_cfg_data;
                CFG_Z_BOUNDS:        r_region_cfg.z_bounds      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Region classifier.
    asau_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_potential   (i_potential),
        .i_activation  (i_activation),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_region_cfg  (r_region_cfg),
        .o_push        (push),
        .o_item        (front_item),
        .i_queue_ready (queue_not_full)
    );

    // Queue between classifier and update pipeline.
    asau_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .o_not_full  (queue_not_full),
        .i_pop       (pop),
        .o_item      (queue_item),
        .o_not_empty (queue_not_empty)
    );

    // Update pipeline.
    asau_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_gain_cfg       (r_gain_cfg),
        .i_queue_valid    (queue_not_empty),
        .i_item           (queue_item),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_new_activation (o_new_activation),
        .o_in_region      (o_in_region),
        .o_saturated      (o_saturated)
    );

endmodule
